// ===== src/hsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsbm_pkg
// Types, codes and constants shared by the two-wire sensor bus master.
// ----------------------------------------------------------------------------
package hsbm_pkg;

  localparam int unsigned CrPulses = 9;
  localparam logic [7:0]  MsbMask  = 8'h80;

  // Register index (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_TEMP_CMD  = 2'd0,
    REG_HUMID_CMD = 2'd1,
    REG_RESET_CMD = 2'd2,
    REG_TIMEOUT   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_TEMP  = 2'd1,
    KIND_HUMID = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    P_IDLE, P_CR_REL, P_CR_SCKL, P_CR_HI, P_CR_LO, P_ST,
    P_WB_SET, P_WB_HI, P_WB_DLY, P_WB_LO, P_WB_REL, P_WB_ACKHI, P_WB_ACKLO,
    P_WAIT, P_RB_REL, P_RB_HI, P_RB_LO, P_RB_ACK, P_RB_ACKHI, P_RB_DLY,
    P_RB_ACKLO, P_RB_FREE
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic       data_in;
  } in_item_t;

  typedef struct packed {
    logic        sck;
    logic        data_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_count;
    logic [15:0] measured_value;
    logic [7:0]  checksum;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  temp_command;
    logic [7:0]  humid_command;
    logic [7:0]  reset_command;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Transmission start: bit1 set selects SCK, else DATA; bit0 is the level
  // (data_low for DATA).
  function automatic logic [1:0] start_action(input logic [2:0] step);
    logic [1:0] a;
    unique case (step)
      3'd0:    a = 2'd0;
      3'd1:    a = 2'd2;
      3'd2:    a = 2'd3;
      3'd3:    a = 2'd1;
      3'd4:    a = 2'd2;
      3'd5:    a = 2'd3;
      3'd6:    a = 2'd0;
      default: a = 2'd2;
    endcase
    return a;
  endfunction

endpackage

// ===== src/humidity_sensor_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_bus_master_core
// Pin-level master for the two-wire humidity/temperature sensor bus.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (kind, data_in)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (pins, status)
//  cfg     | input     | psel, penable, pready    | paddr, pwdata, prdata
//
//  Each transaction is one bus tick and yields exactly one result transaction.
//  A tick passes through the input register, then the sequencer step into the
//  output register. One tick is taken every cycle while the output does not
//  stall; the sequencer state loop (phase and counters updated in a single
//  step) sets that rate. Reset clears both pipeline registers, the sequencer
//  (idle, lines released) and the command registers (3, 5, 30, timeout 65535).
//  A stall on the output holds the result register and backs up to in_stall_o
//  only once the input register is also occupied.
//
module humidity_sensor_bus_master_core import hsbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      advance;
  logic      in_accept;
  logic      cfg_wr;
  cfg_t      cfg_q;
  out_item_t seq_res;
  logic      seq_idle;
  reg_idx_e  reg_sel;

  // Step the sequencer when a tick is held and the result slot is free or
  // being emptied this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accept / advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) in_q  <= in_item_i;
    if (advance)   out_q <= seq_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Register port: zero-wait writes, register picked by address bits [3:2].
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_command  <= 8'd3;
      cfg_q.humid_command <= 8'd5;
      cfg_q.reset_command <= 8'd30;
      cfg_q.timeout_ticks <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TEMP_CMD:  cfg_q.temp_command  <= pwdata[7:0];
        REG_HUMID_CMD: cfg_q.humid_command <= pwdata[7:0];
        REG_RESET_CMD: cfg_q.reset_command <= pwdata[7:0];
        REG_TIMEOUT:   cfg_q.timeout_ticks <= pwdata[15:0];
        default:       cfg_q               <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TEMP_CMD:  prdata = {24'd0, cfg_q.temp_command};
      REG_HUMID_CMD: prdata = {24'd0, cfg_q.humid_command};
      REG_RESET_CMD: prdata = {24'd0, cfg_q.reset_command};
      REG_TIMEOUT:   prdata = {16'd0, cfg_q.timeout_ticks};
      default:       prdata = '0;
    endcase
  end

  // Sequencer: advance one bus action per tick transaction.
  hsbm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg_q),
    .res_o     (seq_res),
    .idle_o    (seq_idle)
  );

  // A finished sequence always reports busy on its last tick.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.done_res || out_q.busy_res))
    else $error("done without busy");

  // A completed sequence returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && seq_res.done_res) |=> seq_idle)
    else $error("sequencer not idle after done");

  // An empty result slot never backs up the input side.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result slot");

  // A stepped tick always lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

endmodule

// ===== src/hsbm_seq.sv =====
// ----------------------------------------------------------------------------
// hsbm_seq
// Bus sequencer: one bus action per advance, state held in registers.
// ----------------------------------------------------------------------------
module hsbm_seq import hsbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o,
  output logic      idle_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  op_kind_q, op_kind_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_cnt_q, wait_cnt_d;
  logic [1:0]  errors_q, errors_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  csum_q, csum_d;
  logic        sck_q, sck_d;
  logic        dlow_q, dlow_d;
  logic        busy, done;
  logic [1:0]  act;
  logic [16:0] wait_inc;
  logic        add_err;

  assign idle_o = (phase_q == P_IDLE);

  always_comb begin
    phase_d    = phase_q;
    op_kind_d  = op_kind_q;
    bit_idx_d  = bit_idx_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    wait_cnt_d = wait_cnt_q;
    errors_d   = errors_q;
    value_d    = value_q;
    csum_d     = csum_q;
    sck_d      = sck_q;
    dlow_d     = dlow_q;
    busy       = 1'b1;
    done       = 1'b0;
    add_err    = 1'b0;
    act        = start_action(bit_idx_q[2:0]);
    wait_inc   = {1'b0, wait_cnt_q} + 17'd1;

    if (phase_q == P_IDLE) begin
      if (item_i.kind == KIND_TICK) begin
        busy = 1'b0;
      end else begin
        op_kind_d  = item_i.kind;
        errors_d   = '0;
        bit_idx_d  = '0;
        byte_idx_d = '0;
        wait_cnt_d = '0;
        phase_d    = (item_i.kind == KIND_RESET) ? P_CR_REL : P_ST;
        act        = start_action(3'd0);
        wait_inc   = 17'd1;
      end
    end

    if (busy) begin
      unique case (phase_d)
        P_CR_REL: begin
          dlow_d = 1'b0; phase_d = P_CR_SCKL;
        end
        P_CR_SCKL: begin
          sck_d = 1'b0; bit_idx_d = '0; phase_d = P_CR_HI;
        end
        P_CR_HI: begin
          sck_d = 1'b1; phase_d = P_CR_LO;
        end
        P_CR_LO: begin
          sck_d = 1'b0;
          if (bit_idx_d >= 4'(CrPulses - 1)) begin
            bit_idx_d = '0; phase_d = P_ST;
          end else begin
            bit_idx_d = bit_idx_d + 4'd1; phase_d = P_CR_HI;
          end
        end
        P_ST: begin
          if (act[1]) sck_d = act[0];
          else        dlow_d = act[0];
          if (bit_idx_d >= 4'd7) begin
            bit_idx_d = '0;
            shift_d   = (op_kind_d == KIND_TEMP)  ? cfg_i.temp_command :
                        (op_kind_d == KIND_HUMID) ? cfg_i.humid_command :
                                                    cfg_i.reset_command;
            phase_d   = P_WB_SET;
          end else begin
            bit_idx_d = bit_idx_d + 4'd1;
          end
        end
        P_WB_SET: begin
          dlow_d = ~|(shift_d & MsbMask); phase_d = P_WB_HI;
        end
        P_WB_HI:  begin sck_d = 1'b1; phase_d = P_WB_DLY; end
        P_WB_DLY: begin phase_d = P_WB_LO; end
        P_WB_LO: begin
          sck_d   = 1'b0;
          shift_d = {shift_d[6:0], 1'b0};
          if (bit_idx_d >= 4'd7) begin
            bit_idx_d = '0; phase_d = P_WB_REL;
          end else begin
            bit_idx_d = bit_idx_d + 4'd1; phase_d = P_WB_SET;
          end
        end
        P_WB_REL:   begin dlow_d = 1'b0; phase_d = P_WB_ACKHI; end
        P_WB_ACKHI: begin sck_d = 1'b1; phase_d = P_WB_ACKLO; end
        P_WB_ACKLO: begin
          add_err = item_i.data_in;
          sck_d   = 1'b0;
          if (op_kind_d == KIND_RESET) begin
            done = 1'b1; phase_d = P_IDLE;
          end else begin
            wait_cnt_d = '0; phase_d = P_WAIT;
          end
        end
        P_WAIT: begin
          if (!item_i.data_in) begin
            phase_d = P_RB_REL;
          end else if (wait_inc >= {1'b0, cfg_i.timeout_ticks}) begin
            add_err = 1'b1; phase_d = P_RB_REL;
          end else begin
            wait_cnt_d = wait_inc[15:0];
          end
        end
        P_RB_REL: begin
          dlow_d = 1'b0; bit_idx_d = '0; shift_d = '0; phase_d = P_RB_HI;
        end
        P_RB_HI: begin sck_d = 1'b1; phase_d = P_RB_LO; end
        P_RB_LO: begin
          if (item_i.data_in) shift_d = shift_d | (MsbMask >> bit_idx_d[2:0]);
          sck_d = 1'b0;
          if (bit_idx_d >= 4'd7) begin
            bit_idx_d = '0;
            if (byte_idx_d == 2'd0)      value_d = {shift_d, value_d[7:0]};
            else if (byte_idx_d == 2'd1) value_d = {value_d[15:8], shift_d};
            else                         csum_d  = shift_d;
            phase_d = P_RB_ACK;
          end else begin
            bit_idx_d = bit_idx_d + 4'd1; phase_d = P_RB_HI;
          end
        end
        P_RB_ACK:   begin dlow_d = (byte_idx_d < 2'd2); phase_d = P_RB_ACKHI; end
        P_RB_ACKHI: begin sck_d = 1'b1; phase_d = P_RB_DLY; end
        P_RB_DLY:   begin phase_d = P_RB_ACKLO; end
        P_RB_ACKLO: begin sck_d = 1'b0; phase_d = P_RB_FREE; end
        P_RB_FREE: begin
          dlow_d = 1'b0;
          if (byte_idx_d >= 2'd2) begin
            done = 1'b1; phase_d = P_IDLE;
          end else begin
            byte_idx_d = byte_idx_d + 2'd1; phase_d = P_RB_REL;
          end
        end
        default: begin
          phase_d = P_IDLE; busy = 1'b0;
        end
      endcase
    end

    // Saturate the error count
    if (add_err && errors_d != 2'd3) errors_d = errors_d + 2'd1;
  end

  always_comb begin
    res_o.sck            = sck_d;
    res_o.data_low       = dlow_d;
    res_o.busy_res       = busy;
    res_o.done_res       = done;
    res_o.error_count    = errors_d;
    res_o.measured_value = value_d;
    res_o.checksum       = csum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_IDLE;
      op_kind_q  <= '0;
      bit_idx_q  <= '0;
      byte_idx_q <= '0;
      shift_q    <= '0;
      wait_cnt_q <= '0;
      errors_q   <= '0;
      value_q    <= '0;
      csum_q     <= '0;
      sck_q      <= 1'b0;
      dlow_q     <= 1'b0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      op_kind_q  <= op_kind_d;
      bit_idx_q  <= bit_idx_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      wait_cnt_q <= wait_cnt_d;
      errors_q   <= errors_d;
      value_q    <= value_d;
      csum_q     <= csum_d;
      sck_q      <= sck_d;
      dlow_q     <= dlow_d;
    end
  end

endmodule
